>>> rtl/assert_macros.svh
// Assertion macros shared by the key matrix scanner RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define KMSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmsp assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define KMSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmsp assertion failed");

`endif

>>> rtl/kmsp_pkg.sv
// Package for the key matrix scanner: beat types, scan map, nav lookup,
// and the controller/datapath command and status structs. No dependencies.
package kmsp_pkg;

  localparam int KEY_COUNT = 56;
  localparam int KEY_COLS  = 14;
  localparam int ROW_INS   = 7;
  localparam int DEC_COLS  = 8;

  localparam logic [2:0] LAST_COL    = 3'd7;
  localparam logic [3:0] LAST_KCOL   = 4'd13;
  localparam logic [5:0] NO_KEY      = 6'h3F;
  localparam logic [6:0] ROW_MASK    = 7'h7F;

  localparam logic [2:0] NAV_NONE  = 3'd0;
  localparam logic [2:0] NAV_UP    = 3'd1;
  localparam logic [2:0] NAV_DOWN  = 3'd2;
  localparam logic [2:0] NAV_LEFT  = 3'd3;
  localparam logic [2:0] NAV_RIGHT = 3'd4;
  localparam logic [2:0] NAV_ENTER = 3'd5;

  typedef logic [KEY_COUNT-1:0] keys_t;

  typedef struct packed {
    logic [2:0] column;
    logic [6:0] row_levels;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] key_row;
    logic [3:0] key_column;
    logic [5:0] key_index;
    logic [2:0] nav_code;
    logic       last_event;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic acc;    // OR the read into the frame
    logic close;  // close frame, load pending presses
    logic emit;   // load result for current index, clear its bit
    logic step;   // advance scan index
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_close;   // input beat is a column 7 read
    logic pend_empty; // no presses left to report
    logic cur_hit;    // current index has a pending press
    logic slot_free;  // output register can take a result
  } sts_t;

  // [decoder column][row input] -> key index
  localparam logic [5:0] SCAN_MAP [DEC_COLS][ROW_INS] = '{
    '{6'd0, 6'd14, 6'd28, 6'd42, 6'd8,  6'd9,  6'd10},
    '{6'd1, 6'd15, 6'd29, 6'd43, 6'd11, 6'd12, 6'd13},
    '{6'd2, 6'd16, 6'd30, 6'd44, 6'd22, 6'd23, 6'd24},
    '{6'd3, 6'd17, 6'd31, 6'd45, 6'd26, 6'd27, NO_KEY},
    '{6'd4, 6'd18, 6'd32, 6'd46, 6'd36, 6'd37, 6'd38},
    '{6'd5, 6'd19, 6'd33, 6'd47, 6'd40, 6'd41, NO_KEY},
    '{6'd6, 6'd20, 6'd34, 6'd48, 6'd50, 6'd51, 6'd52},
    '{6'd7, 6'd21, 6'd35, 6'd49, 6'd54, NO_KEY, NO_KEY}
  };

  function automatic keys_t map_keys(input logic [2:0] col, input logic [6:0] levels);
    keys_t      res;
    logic [6:0] act;
    logic [5:0] k;
    res = '0;
    act = ~levels & ROW_MASK;
    for (int b = 0; b < ROW_INS; b++) begin
      k = SCAN_MAP[col][b];
      if (act[b] && (k != NO_KEY)) begin
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [2:0] nav_of(input logic [5:0] idx);
    logic [2:0] nav;
    unique case (idx)
      6'd39:   nav = NAV_UP;
      6'd53:   nav = NAV_DOWN;
      6'd52:   nav = NAV_LEFT;
      6'd54:   nav = NAV_RIGHT;
      6'd41:   nav = NAV_ENTER;
      default: nav = NAV_NONE;
    endcase
    return nav;
  endfunction

endpackage

>>> rtl/kmsp_ctrl.sv
// Controller FSM for the key matrix scanner: collects reads, then walks
// the pending press vector. Uses kmsp_pkg for command/status structs.
module kmsp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kmsp_pkg::sts_t sts,
  output kmsp_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (sts.is_close) begin
            cmd.close = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sts.pend_empty) begin
          state_nxt = ST_IDLE;
        end else if (sts.cur_hit) begin
          if (sts.slot_free) begin
            cmd.emit = 1'b1;
            cmd.step = 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/kmsp_dp.sv
// Datapath for the key matrix scanner: frame/previous key registers, scan
// index counters and the output register. Uses kmsp_pkg.
module kmsp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  kmsp_pkg::in_beat_t  in_data,
  input  kmsp_pkg::cmd_t      cmd,
  output kmsp_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output kmsp_pkg::out_beat_t out_data
);

  kmsp_pkg::keys_t     frame_r, frame_nxt;
  kmsp_pkg::keys_t     prev_r;
  kmsp_pkg::keys_t     pend_r;
  kmsp_pkg::keys_t     pend_clr;
  kmsp_pkg::keys_t     mapped;
  logic [5:0]          idx_r;
  logic [1:0]          krow_r;
  logic [3:0]          kcol_r;
  logic                out_valid_r;
  kmsp_pkg::out_beat_t out_r;

  assign mapped    = kmsp_pkg::map_keys(in_data.column, in_data.row_levels);
  assign frame_nxt = frame_r | mapped;

  always_comb begin
    pend_clr        = pend_r;
    pend_clr[idx_r] = 1'b0;
  end

  assign sts.is_close   = (in_data.column == kmsp_pkg::LAST_COL);
  assign sts.pend_empty = (pend_r == '0);
  assign sts.cur_hit    = pend_r[idx_r];
  assign sts.slot_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= '0;
      prev_r      <= '0;
      pend_r      <= '0;
      idx_r       <= '0;
      krow_r      <= '0;
      kcol_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc) begin
        if (cmd.close) begin
          frame_r <= '0;
          prev_r  <= frame_nxt;
          pend_r  <= frame_nxt & ~prev_r;
          idx_r   <= '0;
          krow_r  <= '0;
          kcol_r  <= '0;
        end else begin
          frame_r <= frame_nxt;
        end
      end
      if (cmd.emit) begin
        pend_r <= pend_clr;
      end
      if (cmd.step) begin
        idx_r <= idx_r + 6'd1;
        if (kcol_r == kmsp_pkg::LAST_KCOL) begin
          kcol_r <= '0;
          krow_r <= krow_r + 2'd1;
        end else begin
          kcol_r <= kcol_r + 4'd1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.key_row    <= krow_r;
      out_r.key_column <= kcol_r;
      out_r.key_index  <= idx_r;
      out_r.nav_code   <= kmsp_pkg::nav_of(idx_r);
      out_r.last_event <= (pend_clr == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/key_matrix_scan_press_events_core.sv
// Top level of the key matrix scanner: reports newly pressed keys per frame.
// Instantiates kmsp_ctrl and kmsp_dp; uses kmsp_pkg and assert_macros.svh.
//
//   channel | ports                          | beat
//   input   | in_valid, in_ready, in_data    | kmsp_pkg::in_beat_t (column, row_levels)
//   result  | out_valid, out_ready, out_data | kmsp_pkg::out_beat_t (one press event)
//
// A column 0..6 read is ORed into the frame. A column 7 read closes the frame and
// is followed by a walk of the key indexes, one index per cycle up to the highest
// newly pressed key and then a return to idle (with no walk when nothing is new),
// except while a result is stalled on out_ready.
// Input is not taken during the walk. Reset (rst_n low, synchronous) clears
// the frame, previous frame and output valid.
`include "assert_macros.svh"

module key_matrix_scan_press_events_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kmsp_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kmsp_pkg::out_beat_t out_data
);

  kmsp_pkg::cmd_t cmd;
  kmsp_pkg::sts_t sts;

  kmsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kmsp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `KMSP_ASSERT_NXT(a_close_blocks_input, in_valid && in_ready && sts.is_close, !in_ready)
  `KMSP_ASSERT_IMP(a_emit_only_on_hit, cmd.emit, sts.cur_hit && sts.slot_free && !in_ready)
  `KMSP_ASSERT_NXT(a_emit_shows_result, cmd.emit, out_valid)
  `KMSP_ASSERT_IMP(a_acc_only_idle, cmd.acc, in_ready && in_valid)

endmodule

>>> dv/key_matrix_scan_press_events_core_tb.sv
// Testbench for key_matrix_scan_press_events_core: matrix reads in, press events out.
// Scoreboard class predicts events from its own scan map; needs kmsp_pkg and the RTL.
`timescale 1ns / 100ps

module key_matrix_scan_press_events_core_tb;

  localparam logic [5:0] UNMAPPED = 6'h3F;

  // [decoder column][row input] -> key index
  localparam logic [5:0] KEY_AT [8][7] = '{
    '{6'd0, 6'd14, 6'd28, 6'd42, 6'd8,  6'd9,  6'd10},
    '{6'd1, 6'd15, 6'd29, 6'd43, 6'd11, 6'd12, 6'd13},
    '{6'd2, 6'd16, 6'd30, 6'd44, 6'd22, 6'd23, 6'd24},
    '{6'd3, 6'd17, 6'd31, 6'd45, 6'd26, 6'd27, UNMAPPED},
    '{6'd4, 6'd18, 6'd32, 6'd46, 6'd36, 6'd37, 6'd38},
    '{6'd5, 6'd19, 6'd33, 6'd47, 6'd40, 6'd41, UNMAPPED},
    '{6'd6, 6'd20, 6'd34, 6'd48, 6'd50, 6'd51, 6'd52},
    '{6'd7, 6'd21, 6'd35, 6'd49, 6'd54, UNMAPPED, UNMAPPED}
  };

  class press_tracker;
    logic [55:0]         frame_acc;
    logic [55:0]         prev_frame;
    kmsp_pkg::out_beat_t pending_presses[$];
    int                  errors;

    function new();
      frame_acc  = '0;
      prev_frame = '0;
      errors     = 0;
    endfunction

    function logic [2:0] nav_for(input int idx);
      case (idx)
        39:      return kmsp_pkg::NAV_UP;
        53:      return kmsp_pkg::NAV_DOWN;
        52:      return kmsp_pkg::NAV_LEFT;
        54:      return kmsp_pkg::NAV_RIGHT;
        41:      return kmsp_pkg::NAV_ENTER;
        default: return kmsp_pkg::NAV_NONE;
      endcase
    endfunction

    function void note_read(input kmsp_pkg::in_beat_t b);
      logic [6:0]          low;
      logic [5:0]          k;
      logic [55:0]         fresh;
      kmsp_pkg::out_beat_t ev;
      low = ~b.row_levels;
      for (int r = 0; r < 7; r++) begin
        k = KEY_AT[b.column][r];
        if (low[r] && k != UNMAPPED) begin
          frame_acc[k] = 1'b1;
        end
      end
      if (b.column != kmsp_pkg::LAST_COL) return;
      fresh = frame_acc & ~prev_frame;
      for (int i = 0; i < kmsp_pkg::KEY_COUNT; i++) begin
        if (fresh[i]) begin
          ev.key_row    = 2'(i / kmsp_pkg::KEY_COLS);
          ev.key_column = 4'(i % kmsp_pkg::KEY_COLS);
          ev.key_index  = 6'(i);
          ev.nav_code   = nav_for(i);
          ev.last_event = ((fresh >> (i + 1)) == '0);
          pending_presses.push_back(ev);
        end
      end
      prev_frame = frame_acc;
      frame_acc  = '0;
    endfunction

    function void check_event(input kmsp_pkg::out_beat_t got);
      kmsp_pkg::out_beat_t exp;
      if (pending_presses.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected event: idx %0d row %0d col %0d nav %0d last %0d",
                   got.key_index, got.key_row, got.key_column, got.nav_code,
                   got.last_event);
        return;
      end
      exp = pending_presses.pop_front();
      if (got.key_row != exp.key_row || got.key_column != exp.key_column ||
          got.key_index != exp.key_index || got.nav_code != exp.nav_code ||
          got.last_event != exp.last_event) begin
        errors++;
        if (errors <= 10) begin
          $display("event mismatch: exp idx %0d row %0d col %0d nav %0d last %0d",
                   exp.key_index, exp.key_row, exp.key_column, exp.nav_code,
                   exp.last_event);
          $display("                got idx %0d row %0d col %0d nav %0d last %0d",
                   got.key_index, got.key_row, got.key_column, got.nav_code,
                   got.last_event);
        end
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  kmsp_pkg::in_beat_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  kmsp_pkg::out_beat_t out_data;

  press_tracker sb = new();

  int unsigned tx_idle_pct = 38;
  int unsigned rx_idle_pct = 47;
  int unsigned items_sent  = 0;
  logic        hold_req    = 1'b0;
  logic        hold_done   = 1'b0;
  int unsigned hold_left   = 0;

  key_matrix_scan_press_events_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_read(in_data);
      if (out_valid && out_ready) sb.check_event(out_data);
    end
  end

  task automatic send_read(input logic [2:0] col, input logic [6:0] levels);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.column     <= col;
    in_data.row_levels <= levels;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_presses.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  function automatic logic [6:0] row_pattern();
    logic [6:0]  lv;
    int unsigned mode;
    mode = $urandom_range(0, 3);
    lv   = kmsp_pkg::ROW_MASK;
    if (mode == 0) begin
      lv = 7'($urandom_range(0, 127));
    end else if (mode >= 2) begin
      for (int b = 0; b < 7; b++) begin
        if ($urandom_range(0, 5) == 0) lv[b] = 1'b0;
      end
    end
    return lv;
  endfunction

  task automatic run_random(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned count;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        for (int c = 0; c < 8; c++) send_read(3'(c), row_pattern());
      end else if (pick == 7) begin
        // scrambled frame: columns repeated and out of order
        count = $urandom_range(1, 6);
        repeat (count) send_read(3'($urandom_range(0, 6)), row_pattern());
        send_read(kmsp_pkg::LAST_COL, row_pattern());
      end else begin
        send_read(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty frame closes with no events
    send_read(3'd7, 7'h7F);
    // full frame under a long result-side stall
    hold_req <= 1'b1;
    for (int c = 0; c < 8; c++) send_read(3'(c), 7'h00);
    // only already-held keys
    send_read(3'd7, 7'h00);
    // unmapped row inputs only
    send_read(3'd3, 7'h3F);
    send_read(3'd5, 7'h3F);
    send_read(3'd7, 7'h1F);
    // nav keys, repeated column, out of order
    send_read(3'd5, 7'h5F);
    send_read(3'd6, 7'h3F);
    send_read(3'd2, 7'h7E);
    send_read(3'd2, 7'h7D);
    send_read(3'd7, 7'h6F);
    drain_events();

    run_random(114);
    drain_events();

    tx_idle_pct = 47;
    rx_idle_pct <= 38;
    run_random(114);
    drain_events();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_random(114);
    drain_events();

    sb.errors += sb.pending_presses.size();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
